[rtl/core/dfaw_pkg.sv]
`default_nettype none

package dfaw_pkg;

  // Field widths of the beats
  localparam int KIND_W     = 3;
  localparam int STATE_W    = 8;
  localparam int COND_W     = 4;
  localparam int IN_TDATA_W = 24;   // state_index, condition, next_state_value, padded
  localparam int OUT_CNT_W  = 32;
  localparam int OUT_TDATA_W = STATE_W + OUT_CNT_W;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SCNT_W     = 9;
  localparam int CCNT_W     = 5;

  // Defaults for the top-level parameters
  localparam int MAX_STATES_DEF     = 256;
  localparam int MAX_CONDITIONS_DEF = 16;
  localparam int COUNT_WIDTH_DEF    = 32;

  // Register reset values
  localparam logic [SCNT_W-1:0]  STATE_COUNT_RST = 9'd256;
  localparam logic [CCNT_W-1:0]  COND_COUNT_RST  = 5'd16;
  localparam logic [STATE_W-1:0] START_STATE_RST = 8'd0;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 3'd0,
    KIND_STEP    = 3'd1,
    KIND_NODE_RD = 3'd2,
    KIND_EDGE_RD = 3'd3,
    KIND_RESTART = 3'd4
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STATE_COUNT = 2'd0,
    CFG_COND_COUNT  = 2'd1,
    CFG_START_STATE = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/core/dfa_walk_with_visit_profiling.sv]
`default_nettype none

// Channel | Dir | Handshake             | Payload
// in      | in  | in_tvalid/in_tready   | tuser: kind; tdata: state_index, condition, next_state
// out     | out | out_tvalid/out_tready | tuser: error; tdata: cur_state, count_value
// cfg     | in  | cfg_we                | cfg_addr = register index, cfg_wdata = value
//
// Write, read and restart beats are taken one per cycle while the output does not stall; a step
// is held back while a step or restart is still in stage 1, as the walk-state loop runs through
// the registered read of the transition memory. An input beat passes the table/edge read, the
// node read and the output register. After reset a clearing pass over all MAX_STATES*MAX_CONDITIONS
// addresses (4096 by default) zeroes the counters; no input beat is taken during it, cfg writes are.
// Stalls on the output back up through the pipeline; the output register holds one result.
module dfa_walk_with_visit_profiling #(
  parameter int MAX_STATES     = dfaw_pkg::MAX_STATES_DEF,
  parameter int MAX_CONDITIONS = dfaw_pkg::MAX_CONDITIONS_DEF,
  parameter int COUNT_WIDTH    = dfaw_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [dfaw_pkg::IN_TDATA_W-1:0]   in_tdata,  // [7:0] state_index, [11:8] condition,
                                                            // [19:12] next_state_value, rest zero
  input  wire logic [dfaw_pkg::KIND_W-1:0]       in_tuser,  // [2:0] kind
  // result channel
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [dfaw_pkg::OUT_TDATA_W-1:0]  out_tdata, // [7:0] cur_state,
                                                            // [39:8] count_value
  output      logic                              out_tuser, // [0] error
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [dfaw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [dfaw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import dfaw_pkg::*;

  localparam int SW    = $clog2(MAX_STATES);
  localparam int CW    = $clog2(MAX_CONDITIONS);
  localparam int DEPTH = MAX_STATES * MAX_CONDITIONS;
  localparam int AW    = $clog2(DEPTH);

  // Table slot of a (state, condition) pair
  function automatic logic [AW-1:0] slot(input logic [STATE_W-1:0] s,
                                         input logic [COND_W-1:0]  c);
    slot = AW'(SW'(s)) * AW'(MAX_CONDITIONS) + AW'(CW'(c));
  endfunction

  // Saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  // ---------------------------------------------------------------- config
  logic [SCNT_W-1:0]  state_count_r;
  logic [CCNT_W-1:0]  cond_count_r;
  logic [STATE_W-1:0] start_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= STATE_COUNT_RST;
      cond_count_r  <= COND_COUNT_RST;
      start_state_r <= START_STATE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_STATE_COUNT: state_count_r <= cfg_wdata[SCNT_W-1:0];
        CFG_COND_COUNT:  cond_count_r  <= cfg_wdata[CCNT_W-1:0];
        CFG_START_STATE: start_state_r <= cfg_wdata[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits
  logic [SCNT_W-1:0] st_limit;
  logic [CCNT_W-1:0] cd_limit;
  assign st_limit = (32'(state_count_r) > MAX_STATES) ? SCNT_W'(MAX_STATES) : state_count_r;
  assign cd_limit = (32'(cond_count_r) > MAX_CONDITIONS) ? CCNT_W'(MAX_CONDITIONS)
                                                         : cond_count_r;

  // ---------------------------------------------------------------- clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  dfaw_clear #(.DEPTH(DEPTH)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  // ---------------------------------------------------------------- pipeline control
  logic [STATE_W-1:0] walk_r, walk_nxt;

  logic                 p1_valid_r;
  kind_t                p1_kind_r;
  logic [STATE_W-1:0]   p1_s_r;
  logic                 p1_err_r;
  logic [AW-1:0]        p1_eaddr_r;

  logic                   p2_valid_r;
  logic                   p2_bump_r;
  logic                   p2_nread_r;
  logic [SW-1:0]          p2_naddr_r;
  logic                   p2_err_r;
  logic [STATE_W-1:0]     p2_state_r;
  logic [COUNT_WIDTH-1:0] p2_cnt_r;

  logic                 out_valid_r;
  logic [STATE_W-1:0]   out_state_r;
  logic [OUT_CNT_W-1:0] out_count_r;
  logic                 out_err_r;

  logic out_free, p2_move, p2_free, p1_move, p1_free;
  logic step_block, accept;

  assign out_free = !out_valid_r || out_tready;
  assign p2_move  = p2_valid_r && out_free;
  assign p2_free  = !p2_valid_r || p2_move;
  assign p1_move  = p1_valid_r && p2_free;
  assign p1_free  = !p1_valid_r || p1_move;

  // input decode
  kind_t              in_kind;
  logic [STATE_W-1:0] in_s;
  logic [COND_W-1:0]  in_c;
  logic [STATE_W-1:0] in_v;
  assign in_kind = kind_t'(in_tuser);
  assign in_s    = in_tdata[7:0];
  assign in_c    = in_tdata[11:8];
  assign in_v    = in_tdata[19:12];

  // a step needs the walk state left by a step or restart still in stage 1
  assign step_block = p1_valid_r && (p1_kind_r == KIND_STEP || p1_kind_r == KIND_RESTART)
                      && in_kind == KIND_STEP;
  assign in_tready  = !clr_busy && p1_free && !step_block;
  assign accept     = in_tvalid && in_tready;

  // accept-time range checks
  logic s_ok, c_ok, walk_ok, start_ok, in_err;
  assign s_ok     = {1'b0, in_s} < st_limit;
  assign c_ok     = {1'b0, in_c} < cd_limit;
  assign walk_ok  = {1'b0, walk_r} < st_limit;
  assign start_ok = {1'b0, start_state_r} < st_limit;

  always_comb begin
    case (in_kind)
      KIND_WRITE:   in_err = !(s_ok && c_ok);
      KIND_STEP:    in_err = !(walk_ok && c_ok);
      KIND_NODE_RD: in_err = !s_ok;
      KIND_EDGE_RD: in_err = !(s_ok && c_ok);
      KIND_RESTART: in_err = !start_ok;
      default:      in_err = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- transition memory
  logic               tbl_we;
  logic [STATE_W-1:0] tbl_rd;
  assign tbl_we = accept && in_kind == KIND_WRITE && s_ok && c_ok;

  dfaw_ram #(.DEPTH(DEPTH), .WIDTH(STATE_W)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot(in_s, in_c)),
    .wdata (in_v),
    .re    (accept),
    .raddr (slot(walk_r, in_c)),
    .rdata (tbl_rd)
  );

  // ---------------------------------------------------------------- edge counter memory
  logic [AW-1:0]          edge_raddr, edge_waddr;
  logic                   edge_we;
  logic [COUNT_WIDTH-1:0] edge_wdata, edge_rd;
  assign edge_raddr = (in_kind == KIND_STEP) ? slot(walk_r, in_c) : slot(in_s, in_c);

  dfaw_ram #(.DEPTH(DEPTH), .WIDTH(COUNT_WIDTH)) u_edge (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .re    (accept),
    .raddr (edge_raddr),
    .rdata (edge_rd)
  );

  // stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (accept) begin
      p1_valid_r <= 1'b1;
    end else if (p1_move) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_kind_r  <= in_kind;
      p1_s_r     <= in_s;
      p1_err_r   <= in_err;
      p1_eaddr_r <= edge_raddr;
    end
  end

  // ---------------------------------------------------------------- stage 1 compute
  logic                   efwd_valid_r;
  logic [AW-1:0]          efwd_addr_r;
  logic [COUNT_WIDTH-1:0] efwd_data_r;

  logic                   nx_ok, p1_step_go, p1_restart_go, p1_err;
  logic [COUNT_WIDTH-1:0] edge_cur, p1_cnt;
  logic [STATE_W-1:0]     p1_walk_after;

  assign nx_ok         = {1'b0, tbl_rd} < st_limit;
  assign edge_cur      = (efwd_valid_r && efwd_addr_r == p1_eaddr_r) ? efwd_data_r : edge_rd;
  assign p1_step_go    = p1_kind_r == KIND_STEP && !p1_err_r && nx_ok;
  assign p1_restart_go = p1_kind_r == KIND_RESTART && !p1_err_r;
  assign p1_err        = p1_err_r || (p1_kind_r == KIND_STEP && !nx_ok);
  assign p1_cnt        = (p1_kind_r == KIND_EDGE_RD && !p1_err_r) ? edge_cur : '0;

  always_comb begin
    if (p1_step_go) begin
      p1_walk_after = tbl_rd;
    end else if (p1_restart_go) begin
      p1_walk_after = start_state_r;
    end else begin
      p1_walk_after = walk_r;
    end
  end

  assign walk_nxt = p1_move ? p1_walk_after : walk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= START_STATE_RST;
    end else begin
      walk_r <= walk_nxt;
    end
  end

  // edge write: clearing pass or saturating bump of a taken edge
  always_comb begin
    if (clr_busy) begin
      edge_we    = 1'b1;
      edge_waddr = clr_addr;
      edge_wdata = '0;
    end else begin
      edge_we    = p1_move && p1_step_go;
      edge_waddr = p1_eaddr_r;
      edge_wdata = sat_inc(edge_cur);
    end
  end

  // last edge write, forwarded to a read that overlapped it
  always_ff @(posedge clk) begin
    if (!rst_n || clr_busy) begin
      efwd_valid_r <= 1'b0;
    end else if (edge_we) begin
      efwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we && !clr_busy) begin
      efwd_addr_r <= edge_waddr;
      efwd_data_r <= edge_wdata;
    end
  end

  // ---------------------------------------------------------------- node counter memory
  logic                   node_we;
  logic [SW-1:0]          node_waddr, node_raddr;
  logic [COUNT_WIDTH-1:0] node_wdata, node_rd, node_cur;

  logic                   nfwd_valid_r;
  logic [SW-1:0]          nfwd_addr_r;
  logic [COUNT_WIDTH-1:0] nfwd_data_r;

  assign node_raddr = p1_step_go ? SW'(tbl_rd) : SW'(p1_s_r);
  assign node_cur   = (nfwd_valid_r && nfwd_addr_r == p2_naddr_r) ? nfwd_data_r : node_rd;

  always_comb begin
    if (clr_busy) begin
      node_we    = clr_addr < AW'(MAX_STATES);
      node_waddr = SW'(clr_addr);
      node_wdata = '0;
    end else begin
      node_we    = p2_move && p2_bump_r;
      node_waddr = p2_naddr_r;
      node_wdata = sat_inc(node_cur);
    end
  end

  dfaw_ram #(.DEPTH(MAX_STATES), .WIDTH(COUNT_WIDTH)) u_node (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (p1_move),
    .raddr (node_raddr),
    .rdata (node_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clr_busy) begin
      nfwd_valid_r <= 1'b0;
    end else if (node_we) begin
      nfwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we && !clr_busy) begin
      nfwd_addr_r <= node_waddr;
      nfwd_data_r <= node_wdata;
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p1_move) begin
      p2_valid_r <= 1'b1;
    end else if (p2_move) begin
      p2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_bump_r  <= p1_step_go;
      p2_nread_r <= p1_kind_r == KIND_NODE_RD && !p1_err_r;
      p2_naddr_r <= node_raddr;
      p2_err_r   <= p1_err;
      p2_state_r <= p1_walk_after;
      p2_cnt_r   <= p1_cnt;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [COUNT_WIDTH-1:0] p2_count;
  assign p2_count = p2_nread_r ? node_cur : p2_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p2_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_move) begin
      out_state_r <= p2_state_r;
      out_count_r <= OUT_CNT_W'(p2_count);
      out_err_r   <= p2_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_state_r};
  assign out_tuser  = out_err_r;

  // ---------------------------------------------------------------- assertions
  // two steps never enter on adjacent cycles
  a_step_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_STEP) |=> !(accept && in_kind == KIND_STEP))
    else $error("step accepted while previous step still resolving");

  // walk state only moves when stage 1 retires an item
  a_walk_move: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_r != $past(walk_r)) |-> $past(p1_move))
    else $error("walk state changed without a stage 1 retire");

  // a taken step always carries its node bump into stage 2
  a_node_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_move && p1_step_go) |=> (p2_valid_r && p2_bump_r))
    else $error("taken step lost its node count update");

endmodule

`default_nettype wire

[rtl/core/dfaw_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// A read and a write of the same entry in one cycle return the old data.
module dfaw_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/dfaw_clear.sv]
`default_nettype none

// Post-reset sweep: walks every address once so the counter memories
// can be zeroed, one entry per cycle.
module dfaw_clear #(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  output      logic                     busy,
  output      logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] cnt_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (!done_r) begin
      if (cnt_r == AW'(DEPTH - 1)) begin
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign busy = !done_r;
  assign addr = cnt_r;

endmodule

`default_nettype wire
